/* rtl/core/scwm_pkg.sv */
// shared types, constants and the popcount helper for the census window matcher
// no dependencies
`default_nettype none

package scwm_pkg;

  localparam int unsigned NumLanes      = 16;
  localparam int unsigned WordW         = 16;
  localparam int unsigned DescW         = 64;
  localparam int unsigned WordsPerField = DescW / WordW;
  localparam int unsigned NumFields     = NumLanes / WordsPerField;
  localparam int unsigned IdxW          = 12;
  localparam int unsigned DistW         = 9;
  localparam int unsigned BestW         = 10;
  localparam int unsigned LaneCntW      = $clog2(WordW + 1);

  localparam logic [BestW-1:0] BestInit    = BestW'(512);
  localparam logic [DistW-1:0] ThreshReset = DistW'(257);
  localparam logic [DistW-1:0] DistMax     = DistW'(256);

  typedef enum logic {
    ModeLoad    = 1'b0,
    ModeCompare = 1'b1
  } mode_e;

  // control that travels alongside the lane data
  typedef struct packed {
    logic            valid;
    mode_e           mode;
    logic            last;
    logic [IdxW-1:0] idx;
  } pipe_ctrl_t;

  // popcount of a 16 bit word as a shallow tree of nibble counts
  function automatic logic [LaneCntW-1:0] popcount16(input logic [WordW-1:0] v);
    logic [3:0][2:0] nib;
    logic [3:0]      p0;
    logic [3:0]      p1;
    nib[0] = 3'(v[0])  + 3'(v[1])  + 3'(v[2])  + 3'(v[3]);
    nib[1] = 3'(v[4])  + 3'(v[5])  + 3'(v[6])  + 3'(v[7]);
    nib[2] = 3'(v[8])  + 3'(v[9])  + 3'(v[10]) + 3'(v[11]);
    nib[3] = 3'(v[12]) + 3'(v[13]) + 3'(v[14]) + 3'(v[15]);
    p0 = 4'(nib[0]) + 4'(nib[1]);
    p1 = 4'(nib[2]) + 4'(nib[3]);
    return LaneCntW'(p0) + LaneCntW'(p1);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/scwm_lane.sv */
// one compare lane: xor of a reference and a candidate census word, registered popcount
// depends on scwm_pkg
`default_nettype none

module scwm_lane import scwm_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [WordW-1:0]    ref_word_i,
  input  logic [WordW-1:0]    cand_word_i,
  output logic [LaneCntW-1:0] count_o
);

  logic [LaneCntW-1:0] count_q;
  logic [LaneCntW-1:0] count_d;

  assign count_d = popcount16(ref_word_i ^ cand_word_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

/* rtl/core/scwm_merge.sv */
// merge stage: adder tree over the lane counts, winner-takes-all tracking, result register
// depends on scwm_pkg
`default_nettype none

module scwm_merge import scwm_pkg::*; (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pipe_ctrl_t                         ctrl_i,
  input  logic [NumLanes-1:0][LaneCntW-1:0]  counts_i,
  input  logic [DistW-1:0]                   threshold_i,
  input  logic                               out_stall_i,
  output logic                               adv_o,
  output logic                               out_valid_o,
  output logic [IdxW-1:0]                    out_left_index_o,
  output logic [IdxW-1:0]                    out_best_index_o,
  output logic [DistW-1:0]                   out_best_distance_o,
  output logic                               out_match_valid_o
);

  localparam int unsigned L1N = NumLanes / 2;
  localparam int unsigned L2N = NumLanes / 4;
  localparam int unsigned L3N = NumLanes / 8;

  // adder tree
  logic [L1N-1:0][LaneCntW:0]   lvl1;
  logic [L2N-1:0][LaneCntW+1:0] lvl2;
  logic [L3N-1:0][LaneCntW+2:0] lvl3;
  logic [DistW-1:0]             sum_d;
  logic [DistW-1:0]             sum_q;
  pipe_ctrl_t                   ctrl_q;

  always_comb begin
    for (int i = 0; i < L1N; i++) begin
      lvl1[i] = (LaneCntW+1)'(counts_i[2*i]) + (LaneCntW+1)'(counts_i[2*i+1]);
    end
    for (int i = 0; i < L2N; i++) begin
      lvl2[i] = (LaneCntW+2)'(lvl1[2*i]) + (LaneCntW+2)'(lvl1[2*i+1]);
    end
    for (int i = 0; i < L3N; i++) begin
      lvl3[i] = (LaneCntW+3)'(lvl2[2*i]) + (LaneCntW+3)'(lvl2[2*i+1]);
    end
    sum_d = DistW'(lvl3[0]) + DistW'(lvl3[1]);
  end

  // winner-takes-all state
  logic [IdxW-1:0]  ref_idx_q;
  logic [IdxW-1:0]  ref_idx_d;
  logic [BestW-1:0] best_q;
  logic [BestW-1:0] best_d;
  logic [IdxW-1:0]  bidx_q;
  logic [IdxW-1:0]  bidx_d;
  logic             out_valid_q;
  logic             out_valid_d;
  logic [IdxW-1:0]  out_left_q;
  logic [IdxW-1:0]  out_bidx_q;
  logic [DistW-1:0] out_dist_q;
  logic             out_match_q;

  logic             fire;
  logic             emit;
  logic             take;
  logic [BestW-1:0] cand_best;
  logic [IdxW-1:0]  cand_bidx;

  // the pipe only holds when a result is due and the result slot is still stuck
  assign adv_o = !(ctrl_q.valid && (ctrl_q.mode == ModeCompare) && ctrl_q.last &&
                   out_valid_q && out_stall_i);
  assign fire  = adv_o && ctrl_q.valid;
  assign emit  = fire && (ctrl_q.mode == ModeCompare) && ctrl_q.last;

  assign take      = BestW'(sum_q) < best_q;
  assign cand_best = take ? BestW'(sum_q) : best_q;
  assign cand_bidx = take ? ctrl_q.idx : bidx_q;

  always_comb begin
    ref_idx_d = ref_idx_q;
    best_d    = best_q;
    bidx_d    = bidx_q;
    if (fire) begin
      unique case (ctrl_q.mode)
        ModeLoad: begin
          ref_idx_d = ctrl_q.idx;
          best_d    = BestInit;
          bidx_d    = '0;
        end
        ModeCompare: begin
          if (ctrl_q.last) begin
            best_d = BestInit;
            bidx_d = '0;
          end else begin
            best_d = cand_best;
            bidx_d = cand_bidx;
          end
        end
        default: begin
          best_d = best_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      ref_idx_q   <= '0;
      best_q      <= BestInit;
      bidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_o) begin
        ctrl_q <= ctrl_i;
      end
      ref_idx_q   <= ref_idx_d;
      best_q      <= best_d;
      bidx_q      <= bidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      sum_q <= sum_d;
    end
    if (emit) begin
      out_left_q  <= ref_idx_q;
      out_bidx_q  <= cand_bidx;
      out_dist_q  <= DistW'(cand_best);
      out_match_q <= cand_best < BestW'(threshold_i);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_left_index_o    = out_left_q;
  assign out_best_index_o    = out_bidx_q;
  assign out_best_distance_o = out_dist_q;
  assign out_match_valid_o   = out_match_q;

`ifndef SYNTHESIS
  a_best_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_q == BestInit) || (best_q <= BestW'(DistMax)))
    else $error("running best out of range");

  a_best_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_q == BestInit) |-> (bidx_q == '0))
    else $error("best index set without a best distance");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit && out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("emitted result not presented");

  a_match_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_match_q) |-> (out_dist_q < threshold_i))
    else $error("match flag disagrees with threshold");
`endif

endmodule

`default_nettype wire

/* rtl/core/sparse_census_window_matcher.sv */
// sparse census window matcher: an accepted compare beat on the last candidate passes the
// lane, sum and result registers; one beat per cycle on the 16 lanes unless the pipe holds
// reset is asynchronous active low: running best to 512, indexes to 0, threshold to 257,
// pipe and result empty; the reference window holds no reset value until loaded
// the pipe holds only when a result is due and the previous result is still stalled
`default_nettype none

module sparse_census_window_matcher import scwm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [DistW-1:0]  cfg_wdata_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_mode_i,
  input  logic [DescW-1:0]  in_desc_word_0_i,
  input  logic [DescW-1:0]  in_desc_word_1_i,
  input  logic [DescW-1:0]  in_desc_word_2_i,
  input  logic [DescW-1:0]  in_desc_word_3_i,
  input  logic [IdxW-1:0]   in_item_index_i,
  input  logic              in_last_candidate_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IdxW-1:0]   out_left_index_o,
  output logic [IdxW-1:0]   out_best_index_o,
  output logic [DistW-1:0]  out_best_distance_o,
  output logic              out_match_valid_o
);

  // match threshold register
  logic [DistW-1:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // input beat handshake, the whole pipe moves on adv
  logic adv;
  logic accept;

  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  logic [NumFields-1:0][DescW-1:0] cand;

  assign cand[0] = in_desc_word_0_i;
  assign cand[1] = in_desc_word_1_i;
  assign cand[2] = in_desc_word_2_i;
  assign cand[3] = in_desc_word_3_i;

  // reference window, written straight from a load beat so the very next
  // compare beat already sees it in the lanes
  logic [NumFields-1:0][DescW-1:0] ref_win_q;

  always_ff @(posedge clk_i) begin
    if (accept && (mode_e'(in_mode_i) == ModeLoad)) begin
      ref_win_q <= cand;
    end
  end

  // control for stage one, in step with the lane counts
  pipe_ctrl_t ctrl_d;
  pipe_ctrl_t ctrl_q;

  always_comb begin
    ctrl_d.valid = accept;
    ctrl_d.mode  = mode_e'(in_mode_i);
    ctrl_d.last  = in_last_candidate_i;
    ctrl_d.idx   = in_item_index_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv) begin
      ctrl_q <= ctrl_d;
    end
  end

  // sixteen xor / popcount lanes, one census word each
  logic [NumLanes-1:0][LaneCntW-1:0] counts;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    scwm_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (adv),
      .ref_word_i  (ref_win_q[g / WordsPerField][(g % WordsPerField) * WordW +: WordW]),
      .cand_word_i (cand[g / WordsPerField][(g % WordsPerField) * WordW +: WordW]),
      .count_o     (counts[g])
    );
  end

  // adder tree, running best and the result register
  scwm_merge u_merge (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl_q),
    .counts_i            (counts),
    .threshold_i         (thresh_q),
    .out_stall_i         (out_stall_i),
    .adv_o               (adv),
    .out_valid_o         (out_valid_o),
    .out_left_index_o    (out_left_index_o),
    .out_best_index_o    (out_best_index_o),
    .out_best_distance_o (out_best_distance_o),
    .out_match_valid_o   (out_match_valid_o)
  );

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench for sparse_census_window_matcher: load and compare beats go through
// bursty valid/stall traffic and every result is checked against an in-bench predictor
// depends on scwm_pkg and the matcher rtl

module testbench import scwm_pkg::*; ();

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 8;    // drain wait after the last result, leaves margin behind the result pipe
  localparam int LONG_HOLD    = 80;   // receiver hold-off, long enough to back up the pipe
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int WindowBits   = NumFields * DescW;

  typedef logic [NumFields-1:0][DescW-1:0] window_t;

  // one input beat as the driver presents it
  typedef struct packed {
    mode_e           mode;
    window_t         desc;
    logic [IdxW-1:0] idx;
    logic            last;
  } window_beat_t;

  // one result beat
  typedef struct packed {
    logic [IdxW-1:0]  left;
    logic [IdxW-1:0]  best;
    logic [DistW-1:0] distance;
    logic             hit;
  } match_t;

  // dut pins, the inputs all known from time zero
  logic             clk_i               = 1'b0;
  logic             rst_ni              = 1'b0;
  logic             cfg_we_i            = 1'b0;
  logic [DistW-1:0] cfg_wdata_i         = '0;
  logic             in_valid_i          = 1'b0;
  logic             in_stall_o;
  logic             in_mode_i           = 1'b0;
  logic [DescW-1:0] in_desc_word_0_i    = '0;
  logic [DescW-1:0] in_desc_word_1_i    = '0;
  logic [DescW-1:0] in_desc_word_2_i    = '0;
  logic [DescW-1:0] in_desc_word_3_i    = '0;
  logic [IdxW-1:0]  in_item_index_i     = '0;
  logic             in_last_candidate_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i         = 1'b0;
  logic [IdxW-1:0]  out_left_index_o;
  logic [IdxW-1:0]  out_best_index_o;
  logic [DistW-1:0] out_best_distance_o;
  logic             out_match_valid_o;

  // beats waiting for the driver and results still owed by the dut
  window_beat_t pending_beats[$];
  match_t       due_matches[$];
  int           error_count = 0;

  // predictor state, advanced on every accepted beat
  window_t          ref_window    = '0;
  logic [IdxW-1:0]  left_idx      = '0;
  logic [BestW-1:0] run_best_dist = BestInit;
  logic [IdxW-1:0]  run_best_idx  = '0;
  logic [DistW-1:0] threshold_now = ThreshReset;

  // generator's view of the reference, runs ahead of the predictor
  window_t gen_window = '0;

  // driver and receiver pacing
  window_beat_t shown_beat;
  int           burst_left   = 0;
  int           gap_left     = 0;
  int           hold_left    = 0;
  int           pattern_left = 0;
  int           stall_pct    = 0;
  logic         hold_request = 1'b0;
  match_t       got;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sparse_census_window_matcher u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_mode_i           (in_mode_i),
    .in_desc_word_0_i    (in_desc_word_0_i),
    .in_desc_word_1_i    (in_desc_word_1_i),
    .in_desc_word_2_i    (in_desc_word_2_i),
    .in_desc_word_3_i    (in_desc_word_3_i),
    .in_item_index_i     (in_item_index_i),
    .in_last_candidate_i (in_last_candidate_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_left_index_o    (out_left_index_o),
    .out_best_index_o    (out_best_index_o),
    .out_best_distance_o (out_best_distance_o),
    .out_match_valid_o   (out_match_valid_o)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // hamming distance over the whole window: 16 words of 16 bits add up the same
  // as the four 64 bit fields taken at once
  function automatic int unsigned census_distance(input window_t a, input window_t b);
    int unsigned sum;
    sum = 0;
    for (int f = 0; f < NumFields; f++) begin
      sum += $countones(a[f] ^ b[f]);
    end
    return sum;
  endfunction

  // advance the winner-takes-all state by one accepted beat, queue a result on a last
  // candidate
  function automatic void match_window_beat(input window_beat_t b);
    int unsigned d;
    match_t      m;
    if (b.mode == ModeLoad) begin
      // new reference, running best starts over, last flag has no effect
      ref_window    = b.desc;
      left_idx      = b.idx;
      run_best_dist = BestInit;
      run_best_idx  = '0;
    end else begin
      d = census_distance(ref_window, b.desc);
      // strictly smaller only, so the earliest candidate keeps a tie
      if (d < run_best_dist) begin
        run_best_dist = BestW'(d);
        run_best_idx  = b.idx;
      end
      if (b.last) begin
        m.left     = left_idx;
        m.best     = run_best_idx;
        m.distance = run_best_dist[DistW-1:0];
        m.hit      = (run_best_dist < BestW'(threshold_now));
        due_matches = {due_matches, m};
        run_best_dist = BestInit;
        run_best_idx  = '0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_beat(input mode_e mode, input window_t desc,
                                    input int unsigned idx, input logic last);
    window_beat_t b;
    b.mode = mode;
    b.desc = desc;
    b.idx  = IdxW'(idx);
    b.last = last;
    if (mode == ModeLoad) begin
      gen_window = desc;
    end
    pending_beats = {pending_beats, b};
  endfunction

  function automatic window_t random_window();
    window_t w;
    for (int f = 0; f < NumFields; f++) begin
      w[f] = {$urandom, $urandom};
    end
    return w;
  endfunction

  // flip n random bits; repeats can cancel, so the distance is at most n
  function automatic window_t flip_bits(input window_t w, input int n);
    window_t     r;
    int unsigned pos;
    r = w;
    for (int k = 0; k < n; k++) begin
      pos = $urandom_range(0, WindowBits - 1);
      r[pos / DescW][pos % DescW] = ~r[pos / DescW][pos % DescW];
    end
    return r;
  endfunction

  // reference windows: mostly random, sometimes sparse or saturated
  function automatic window_t pick_reference();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return flip_bits('0, $urandom_range(1, 20));
      default: return random_window();
    endcase
  endfunction

  // candidates cluster around the reference and the current threshold, where the
  // interesting decisions happen
  function automatic window_t pick_candidate();
    int n;
    case ($urandom_range(0, 11))
      0:       return gen_window;
      1:       return ~gen_window;
      2, 3:    return random_window();
      4, 5, 6: begin
        n = int'(threshold_now) + $urandom_range(0, 8) - 4;
        if (n < 0) n = 0;
        return flip_bits(gen_window, n);
      end
      default: return flip_bits(gen_window, $urandom_range(0, 40));
    endcase
  endfunction

  // runs of compares with random content, an occasional load between runs and, more
  // rarely, a load that breaks into a run
  task automatic queue_random_runs(input int n_beats);
    int sent;
    int run_len;
    sent = 0;
    if ($urandom_range(0, 1) == 0 || sent == 0) begin
      push_beat(ModeLoad, pick_reference(), $urandom_range(0, 4095), 1'($urandom));
      sent++;
    end
    while (sent < n_beats) begin
      if ($urandom_range(0, 9) == 0) begin
        push_beat(ModeLoad, pick_reference(), $urandom_range(0, 4095), 1'($urandom));
        sent++;
      end
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 60) == 0) begin
          push_beat(ModeLoad, pick_reference(), $urandom_range(0, 4095), 1'($urandom));
          sent++;
        end
        push_beat(ModeCompare, pick_candidate(), $urandom_range(0, 4095), k == run_len - 1);
      end
      sent += run_len;
    end
  endtask

  // fixed corner cases: zero and full distance, ties, extreme indexes, a load that
  // breaks into a run, and a reference that stays loaded across runs
  task automatic queue_directed();
    window_t stripes;
    stripes = {NumFields{64'hA5A5_5A5A_F00F_0FF0}};
    // load first so no compare ever sees an unwritten reference; last is ignored here
    push_beat(ModeLoad, '0, 0, 1'b1);
    push_beat(ModeCompare, '0, 4095, 1'b1);
    // two candidates at full distance, the earlier one must win
    push_beat(ModeCompare, '1, 0, 1'b0);
    push_beat(ModeCompare, '1, 5, 1'b1);
    push_beat(ModeLoad, '1, 4095, 1'b0);
    push_beat(ModeCompare, '0, 1, 1'b0);
    push_beat(ModeCompare, flip_bits('1, 1), 2, 1'b0);
    push_beat(ModeCompare, ~window_t'(1), 3, 1'b0);
    push_beat(ModeCompare, ~window_t'({1'b1, 155'd0, 1'b1, 92'd0, 7'h7}), 4, 1'b1);
    // perfect match thrown away by a load in the middle of the run
    push_beat(ModeCompare, '1, 7, 1'b0);
    push_beat(ModeLoad, stripes, 12'hA5A, 1'b1);
    push_beat(ModeCompare, stripes ^ window_t'(64'h3FF), 9, 1'b1);
    push_beat(ModeCompare, ~stripes, 12'h555, 1'b1);
    // distance in the top word only, then two exact copies
    push_beat(ModeCompare, stripes ^ {64'h8000_0000_0000_0000, 192'd0}, 4094, 1'b0);
    push_beat(ModeCompare, stripes, 1, 1'b0);
    push_beat(ModeCompare, stripes, 2, 1'b1);
    push_beat(ModeCompare, stripes ^ {64'h0001_0000_0000_0000, 128'd0, 64'h1}, 2048, 1'b1);
  endtask

  // everything sent, every result back, then let the pipe drain
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_beats.size() != 0 || in_valid_i || due_matches.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // threshold write, only while the block is idle
  task automatic write_threshold(input logic [DistW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    threshold_now = value;
    @(negedge clk_i);
  endtask

  function automatic void check_field(input string field, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents pending beats in bursts with random gaps, scores each accepted
  // beat, holds the payload while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        match_window_beat(shown_beat);
      end
      // a new beat or a gap only once the current beat is gone
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          shown_beat = pending_beats.pop_front();
          in_valid_i          <= 1'b1;
          in_mode_i           <= shown_beat.mode;
          in_desc_word_0_i    <= shown_beat.desc[0];
          in_desc_word_1_i    <= shown_beat.desc[1];
          in_desc_word_2_i    <= shown_beat.desc[2];
          in_desc_word_3_i    <= shown_beat.desc[3];
          in_item_index_i     <= shown_beat.idx;
          in_last_candidate_i <= shown_beat.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // end of a burst: pick the next burst and the gap in front of it;
            // a zero gap gives back-to-back stretches
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern whose density changes from stretch to stretch, plus one
  // long hold-off on request so results back up into the input
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left    = 0;
      pattern_left = 0;
      stall_pct    = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 80);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 20;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        pattern_left--;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every accepted result beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_matches.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0d %0d %0d %0b",
                 $time, out_left_index_o, out_best_index_o, out_best_distance_o,
                 out_match_valid_o);
        error_count++;
      end else begin
        got = due_matches.pop_front();
        check_field("left_index", 16'(got.left), 16'(out_left_index_o));
        check_field("best_index", 16'(got.best), 16'(out_best_index_o));
        check_field("best_distance", 16'(got.distance), 16'(out_best_distance_o));
        check_field("match_valid", 16'(got.hit), 16'(out_match_valid_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed beats at the reset threshold, then random phases each
  // behind a threshold write; every phase ends with the sender waiting for all results
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_thresholds [7];
    phase_thresholds = '{0, 256, 257, 1, 255, 0, 0};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_directed();
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      // the last two phases sit at a random level inside the usual distance spread
      if (phase_thresholds[p] == 0 && p >= 5) begin
        phase_thresholds[p] = $urandom_range(60, 200);
      end
      write_threshold(DistW'(phase_thresholds[p]));
      if (p == 5) begin
        // back-to-back single candidate runs while the receiver holds off
        hold_request = 1'b1;
        push_beat(ModeLoad, pick_reference(), $urandom_range(0, 4095), 1'b0);
        for (int k = 0; k < 60; k++) begin
          push_beat(ModeCompare, pick_candidate(), $urandom_range(0, 4095), 1'b1);
        end
      end
      queue_random_runs(260);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/scwm_pkg.sv
rtl/core/scwm_lane.sv
rtl/core/scwm_merge.sv
rtl/core/sparse_census_window_matcher.sv
bench/testbench.sv
